/* hdl/jac_pkg.sv */
// Shared constants, types and codes of the joystick axis conditioner.
`default_nettype none
package jac_pkg;

  localparam int NUM_STICKS_DEF  = 8;
  localparam int CAL_RUN_DEF     = 16;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int STICK_W  = 3;
  localparam int SAMPLE_W = 12;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int CENTER_W = 12;
  localparam int FRAC_BITS = 14;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int DZ_W   = 12;
  localparam logic [DZ_W-1:0] DZ_RESET = 12'd32;
  localparam logic REG_DEADZONE = 1'b0;

  localparam logic [VALUE_W-1:0] ONE_Q14 = 16'd16384;

  typedef enum logic [STATUS_W-1:0] {
    STS_VALUE = 2'd0,
    STS_UNCAL = 2'd1,
    STS_FAIL  = 2'd2,
    STS_CAL   = 2'd3
  } jac_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } jac_state_t;

  typedef struct packed {
    logic start;
    logic mean;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

/* hdl/jac_if.sv */
// Valid/ready channel interfaces for sample words and result words.
`default_nettype none
interface jac_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [jac_pkg::STICK_W-1:0]    stick;
  logic                           axis_sel;
  logic [jac_pkg::SAMPLE_W-1:0]   sample;
  logic                           sample_ok;

  modport source (output valid, func, stick, axis_sel, sample, sample_ok, input ready);
  modport sink (input valid, func, stick, axis_sel, sample, sample_ok, output ready);
endinterface

interface jac_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [jac_pkg::VALUE_W-1:0]  axis_value;
  logic [jac_pkg::STATUS_W-1:0]        status;
  logic [jac_pkg::CENTER_W-1:0]        center_now;

  modport source (output valid, axis_value, status, center_now, input ready);
  modport sink (input valid, axis_value, status, center_now, output ready);
endinterface
`default_nettype wire

/* hdl/jac_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module jac_div #(
  parameter int DIV_W = 12,
  parameter int QW    = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire jac_pkg::div_ctl_t ctl,
  input  wire logic [DIV_W-1:0] rem_init,
  input  wire logic [QW-1:0]    dvd_init,
  input  wire logic [DIV_W-1:0] divisor,
  output jac_pkg::div_sts_t     sts,
  output logic [QW-1:0]         quot
);

  localparam int CW = $clog2(QW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [QW-1:0]    dvd_r, dvd_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [DIV_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[QW-1]};
    ge       = rem_sh >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ctl.mean ? CW'(QW) : CW'(jac_pkg::FRAC_BITS);
      rem_nxt  = rem_init;
      dvd_nxt  = dvd_init;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_W'(rem_sh - {1'b0, dsr_r}) : DIV_W'(rem_sh);
      dvd_nxt = {dvd_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts  = '{busy: busy_r, done: done_r};
  assign quot = dvd_r;

endmodule
`default_nettype wire

/* hdl/joystick_axis_conditioner.sv */
// Joystick axis conditioner: calibration and Q2.14 normalisation of ADC samples.
//
// in_bus carries one sample word (func, stick, axis_sel, sample, sample_ok);
// every accepted word gives exactly one result word on out_bus (axis_value,
// status, center_now). Words are taken one at a time: in_bus.ready is high
// only while no word is in progress.
// Each accepted word is latched while its center is read from the center
// memory. Calibration samples, failed or uncalibrated reads, deadzone hits
// and clamped reads then go straight to the output register; reads that
// need the 14 quotient bits of the serial divider, and the sample that ends
// a calibration run, where the divider forms the mean, first wait for the
// shared divider.
// The finished word waits in the output register, so a stalled receiver
// only delays the next word once the block has its next result ready.
// Reset (synchronous, rst_n low) clears the calibration run, marks every
// axis uncalibrated (centers read as mid scale) and sets deadzone to 32.
// The deadzone register sits at byte address 0 of the cfg_ APB port.
`default_nettype none
module joystick_axis_conditioner #(
  parameter int NUM_STICKS  = jac_pkg::NUM_STICKS_DEF,
  parameter int CAL_RUN     = jac_pkg::CAL_RUN_DEF,
  parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  jac_in_if.sink                          in_bus,
  jac_out_if.source                       out_bus,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [jac_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [jac_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [jac_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);

  localparam int AXES  = 2 * NUM_STICKS;
  localparam int IDX_W = $clog2(AXES);
  localparam int SB    = SAMPLE_BITS;
  localparam int CNT_W = $clog2(CAL_RUN + 1);
  localparam int SUM_W = SB + CNT_W;
  localparam int QW    = (SUM_W > jac_pkg::FRAC_BITS + 1) ? SUM_W : jac_pkg::FRAC_BITS + 1;
  localparam int MW    = (SB > jac_pkg::DZ_W) ? SB : jac_pkg::DZ_W;
  localparam int VW    = jac_pkg::VALUE_W;
  localparam logic [SB-1:0] FULL_SCALE = {SB{1'b1}};
  localparam logic [SB-1:0] MID_SCALE  = {1'b1, {(SB-1){1'b0}}};

  jac_pkg::jac_state_t st_r, st_nxt;

  logic                    func_r, ok_r, stick_ok_r;
  logic [IDX_W-1:0]        idx_r;
  logic [SB-1:0]           sample_r;
  logic                    in_acc;

  logic [SUM_W-1:0]        cal_sum_r, cal_sum_nxt;
  logic [CNT_W-1:0]        cal_good_r, cal_good_nxt;
  logic [CNT_W-1:0]        cal_tries_r, cal_tries_nxt;
  logic [IDX_W-1:0]        cal_target_r, cal_target_nxt;
  logic [AXES-1:0]         calibrated_r, calibrated_nxt;
  logic [jac_pkg::DZ_W-1:0] deadzone_r;

  logic [SB-1:0]           centers_mem [AXES];
  logic [SB-1:0]           mem_q_r;
  logic                    mem_we;
  logic [SB-1:0]           mem_wd;
  logic [IDX_W-1:0]        rd_idx;

  logic [VW-1:0]           res_value_r, res_value_nxt;
  jac_pkg::jac_status_t    res_status_r, res_status_nxt;
  logic [SB-1:0]           res_center_r, res_center_nxt;
  logic                    neg_r, neg_nxt;
  logic                    mean_r, mean_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [VW-1:0]           out_value_r;
  logic [jac_pkg::STATUS_W-1:0] out_status_r;
  logic [jac_pkg::CENTER_W-1:0] out_center_r;
  logic                    out_load;

  jac_pkg::div_ctl_t       div_ctl;
  jac_pkg::div_sts_t       div_sts;
  logic [SB-1:0]           div_rem;
  logic [QW-1:0]           div_dvd;
  logic [SB-1:0]           div_dsr;
  logic [QW-1:0]           div_quot;

  logic [SB-1:0]           center_cur;
  logic                    fresh, run_end, both_cal;
  logic [SUM_W-1:0]        sum1;
  logic [CNT_W-1:0]        good1, tries1;
  logic [SB:0]             diff;
  logic                    dneg, dpos;
  logic [SB-1:0]           mag, range_v;
  logic [IDX_W-1:0]        idx_x, idx_y;
  logic [VW-1:0]           qval;

  assign in_bus.ready = (st_r == jac_pkg::ST_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign rd_idx       = IDX_W'({in_bus.stick, in_bus.axis_sel});

  // configuration port
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= jac_pkg::DZ_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == jac_pkg::REG_DEADZONE) begin
      deadzone_r <= cfg_pwdata[jac_pkg::DZ_W-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == jac_pkg::REG_DEADZONE) ?
                      jac_pkg::CFG_DW'(deadzone_r) : '0;

  // center memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      centers_mem[idx_r] <= mem_wd;
    end
    if (in_acc) begin
      mem_q_r <= centers_mem[rd_idx];
    end
  end

  // latch the accepted word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r     <= in_bus.func;
      ok_r       <= in_bus.sample_ok;
      idx_r      <= rd_idx;
      sample_r   <= SB'(in_bus.sample);
      stick_ok_r <= int'(in_bus.stick) < NUM_STICKS;
    end
  end

  jac_div #(
    .DIV_W (SB),
    .QW    (QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .rem_init (div_rem),
    .dvd_init (div_dvd),
    .divisor  (div_dsr),
    .sts      (div_sts),
    .quot     (div_quot)
  );

  always_comb begin
    center_cur = calibrated_r[idx_r] ? mem_q_r : MID_SCALE;
    idx_x      = idx_r & ~IDX_W'(1);
    idx_y      = idx_r | IDX_W'(1);
    both_cal   = calibrated_r[idx_x] && calibrated_r[idx_y];

    fresh   = (cal_tries_r == '0) || (cal_target_r != idx_r);
    sum1    = (fresh ? '0 : cal_sum_r) + (ok_r ? SUM_W'(sample_r) : '0);
    good1   = (fresh ? '0 : cal_good_r) + CNT_W'(ok_r);
    tries1  = (fresh ? '0 : cal_tries_r) + CNT_W'(1);
    run_end = (tries1 == CNT_W'(CAL_RUN));

    diff    = {1'b0, sample_r} - {1'b0, center_cur};
    dneg    = diff[SB];
    dpos    = !dneg && (diff != '0);
    mag     = dneg ? SB'(-diff) : diff[SB-1:0];
    range_v = dpos ? FULL_SCALE - center_cur : center_cur;
    qval    = VW'(div_quot[jac_pkg::FRAC_BITS-1:0]);

    st_nxt         = st_r;
    cal_sum_nxt    = cal_sum_r;
    cal_good_nxt   = cal_good_r;
    cal_tries_nxt  = cal_tries_r;
    cal_target_nxt = cal_target_r;
    calibrated_nxt = calibrated_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    res_center_nxt = res_center_r;
    neg_nxt        = neg_r;
    mean_nxt       = mean_r;
    mem_we         = 1'b0;
    mem_wd         = MID_SCALE;
    div_ctl.start  = 1'b0;
    div_ctl.mean   = 1'b0;
    div_rem        = '0;
    div_dvd        = '0;
    div_dsr        = '0;
    out_load       = 1'b0;

    case (st_r)
      jac_pkg::ST_IDLE: begin
        if (in_acc) begin
          st_nxt = jac_pkg::ST_READ;
        end
      end
      jac_pkg::ST_READ: begin
        res_value_nxt  = '0;
        res_center_nxt = center_cur;
        st_nxt         = jac_pkg::ST_DONE;
        if (!stick_ok_r) begin
          res_status_nxt = jac_pkg::STS_UNCAL;
          res_center_nxt = '0;
        end else if (!func_r) begin
          res_status_nxt = jac_pkg::STS_CAL;
          cal_target_nxt = idx_r;
          if (run_end) begin
            cal_sum_nxt   = '0;
            cal_good_nxt  = '0;
            cal_tries_nxt = '0;
            if (good1 == '0) begin
              mem_we                = 1'b1;
              calibrated_nxt[idx_r] = 1'b1;
              res_center_nxt        = MID_SCALE;
            end else begin
              div_ctl.start = 1'b1;
              div_ctl.mean  = 1'b1;
              div_dvd       = QW'(sum1);
              div_dsr       = SB'(good1);
              mean_nxt      = 1'b1;
              st_nxt        = jac_pkg::ST_DIV;
            end
          end else begin
            cal_sum_nxt   = sum1;
            cal_good_nxt  = good1;
            cal_tries_nxt = tries1;
          end
        end else if (!both_cal) begin
          res_status_nxt = jac_pkg::STS_UNCAL;
        end else if (!ok_r) begin
          res_status_nxt = jac_pkg::STS_FAIL;
        end else begin
          res_status_nxt = jac_pkg::STS_VALUE;
          if ((MW'(mag) < MW'(deadzone_r)) || (range_v == '0)) begin
            res_value_nxt = '0;
          end else if (mag >= range_v) begin
            res_value_nxt = dpos ? VW'(0) - jac_pkg::ONE_Q14 : jac_pkg::ONE_Q14;
          end else begin
            div_ctl.start = 1'b1;
            div_rem       = mag;
            div_dsr       = range_v;
            neg_nxt       = dpos;
            mean_nxt      = 1'b0;
            st_nxt        = jac_pkg::ST_DIV;
          end
        end
      end
      jac_pkg::ST_DIV: begin
        if (div_sts.done) begin
          st_nxt = jac_pkg::ST_DONE;
          if (mean_r) begin
            mem_we                = 1'b1;
            mem_wd                = SB'(div_quot);
            calibrated_nxt[idx_r] = 1'b1;
            res_center_nxt        = SB'(div_quot);
          end else begin
            res_value_nxt = neg_r ? VW'(0) - qval : qval;
          end
        end
      end
      jac_pkg::ST_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_load = 1'b1;
          st_nxt   = jac_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = jac_pkg::ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= jac_pkg::ST_IDLE;
      cal_sum_r    <= '0;
      cal_good_r   <= '0;
      cal_tries_r  <= '0;
      cal_target_r <= '0;
      calibrated_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      cal_sum_r    <= cal_sum_nxt;
      cal_good_r   <= cal_good_nxt;
      cal_tries_r  <= cal_tries_nxt;
      cal_target_r <= cal_target_nxt;
      calibrated_r <= calibrated_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    res_center_r <= res_center_nxt;
    neg_r        <= neg_nxt;
    mean_r       <= mean_nxt;
    if (out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_center_r <= jac_pkg::CENTER_W'(res_center_r);
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.axis_value = out_value_r;
  assign out_bus.status     = out_status_r;
  assign out_bus.center_now = out_center_r;

endmodule
`default_nettype wire

/* hdl/jac_chk.sv */
// Port-level checks of the joystick axis conditioner, bound to the top level.
`default_nettype none
module jac_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic signed [jac_pkg::VALUE_W-1:0] out_axis_value,
  input wire logic [jac_pkg::STATUS_W-1:0]     out_status,
  input wire logic [jac_pkg::CENTER_W-1:0]     out_center_now
);

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while another is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_axis_value) &&
      $stable(out_status) && $stable(out_center_now))
    else $error("stalled result word changed");

  a_zero_unless_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != jac_pkg::STS_VALUE |-> out_axis_value == '0)
    else $error("non-zero axis value on a non-value status");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_axis_value <= 16'sd16384 && out_axis_value >= -16'sd16384)
    else $error("axis value beyond plus or minus one");

endmodule

bind joystick_axis_conditioner jac_chk u_jac_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_axis_value (out_bus.axis_value),
  .out_status     (out_bus.status),
  .out_center_now (out_bus.center_now)
);
`default_nettype wire
